/* src/ansi_sgr_style_tracker_assert.svh */
// assertion macros shared by the style tracker rtl
`ifndef ANSI_SGR_STYLE_TRACKER_ASSERT_SVH
`define ANSI_SGR_STYLE_TRACKER_ASSERT_SVH

// checked on every rising edge, muted while reset is high
`define SGR_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising edge, reset included
`define SGR_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/sgr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_pkg
// Parameter codes, style bit positions, stream widths and the 16-entry
// color palette for the sgr style tracker.
// ----------------------------------------------------------------------------
package sgr_pkg;

   // stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 64;

   // sgr parameter codes
   localparam logic [7:0] SGR_RESET        = 8'd0;
   localparam logic [7:0] SGR_BOLD         = 8'd1;
   localparam logic [7:0] SGR_DIM          = 8'd2;
   localparam logic [7:0] SGR_UNDER        = 8'd4;
   localparam logic [7:0] SGR_REVERSE      = 8'd7;
   localparam logic [7:0] SGR_NORMAL       = 8'd22;
   localparam logic [7:0] SGR_UNDER_OFF    = 8'd24;
   localparam logic [7:0] SGR_REVERSE_OFF  = 8'd27;
   localparam logic [7:0] SGR_FG_LO        = 8'd30;
   localparam logic [7:0] SGR_FG_HI        = 8'd37;
   localparam logic [7:0] SGR_FG_DEFAULT   = 8'd39;
   localparam logic [7:0] SGR_BG_LO        = 8'd40;
   localparam logic [7:0] SGR_BG_HI        = 8'd47;
   localparam logic [7:0] SGR_BG_DEFAULT   = 8'd49;
   localparam logic [7:0] SGR_FG_BRIGHT_LO = 8'd90;
   localparam logic [7:0] SGR_FG_BRIGHT_HI = 8'd97;
   localparam logic [7:0] SGR_BG_BRIGHT_LO = 8'd100;
   localparam logic [7:0] SGR_BG_BRIGHT_HI = 8'd107;

   // style bit positions
   localparam int ATTR_BOLD  = 0;
   localparam int ATTR_DIM   = 1;
   localparam int ATTR_UNDER = 2;
   localparam int ATTR_REV   = 3;

   // default style
   localparam logic [3:0] FORE_DEFAULT  = 4'd7;
   localparam logic [3:0] BACK_DEFAULT  = 4'd0;
   localparam logic [3:0] STYLE_DEFAULT = 4'd0;

   // dim keeps seven bits of every channel
   localparam logic [23:0] HALF_MASK = 24'h7f7f7f;

   typedef logic [23:0] rgb_type;

   // 16-color palette, red in the high byte
   localparam rgb_type PALETTE [16] = '{
      24'h000000, 24'h800000, 24'h008000, 24'h808000,
      24'h000080, 24'h800080, 24'h008080, 24'hc0c0c0,
      24'h808080, 24'hff0000, 24'h00ff00, 24'hffff00,
      24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff
   };

endpackage
`default_nettype wire

/* src/ansi_sgr_style_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// rsp_tvalid rises once a taken request has passed the input register and the
// result register. Throughput: one transaction per cycle while rsp_tready holds,
// set by the single decode and palette lookup between the two registers.
// While a result waits on rsp_tready, only an empty input register takes one more.
// Reset (synchronous, active high) empties both registers and loads the
// default style: foreground 7, background 0, no attributes.
// ----------------------------------------------------------------------------
// ansi_sgr_style_tracker
// Keeps a terminal text style set by one sgr parameter per transaction (action
// bit set: defaults) and returns effective colors and stored style after each.
// ----------------------------------------------------------------------------
`include "ansi_sgr_style_tracker_assert.svh"

module ansi_sgr_style_tracker
   import sgr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] sgr_param
   input  wire logic                  req_tuser,  // [0] action
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [23:0] fg_rgb, [47:24] bg_rgb, [48] underline_on, [52:49] fg_code,
   // [56:53] bg_code, [60:57] attr_flags, [63:61] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic                  in_valid_ff;
   logic                  action_ff;
   logic [7:0]            param_ff;
   logic [3:0]            fore_ff, fore_in;
   logic [3:0]            back_ff, back_in;
   logic [3:0]            style_ff, style_in;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_ready;
   logic                  step;
   logic [3:0]            fg_lookup;
   rgb_type               fg_rgb, bg_rgb, fg_eff, bg_eff;

   // handshakes
   assign rsp_ready  = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || rsp_ready;
   assign step       = in_valid_ff && rsp_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         action_ff <= req_tuser;
         param_ff  <= req_tdata;
      end
   end

   // parameter decode into the next style
   always_comb begin
      fore_in  = fore_ff;
      back_in  = back_ff;
      style_in = style_ff;
      if (action_ff) begin
         fore_in  = FORE_DEFAULT;
         back_in  = BACK_DEFAULT;
         style_in = STYLE_DEFAULT;
      end else begin
         unique case (param_ff) inside
            SGR_RESET: begin
               fore_in  = FORE_DEFAULT;
               back_in  = BACK_DEFAULT;
               style_in = STYLE_DEFAULT;
            end
            SGR_BOLD: begin
               style_in[ATTR_BOLD] = 1'b1;
               style_in[ATTR_DIM]  = 1'b0;
            end
            SGR_DIM: begin
               style_in[ATTR_DIM]  = 1'b1;
               style_in[ATTR_BOLD] = 1'b0;
            end
            SGR_UNDER:       style_in[ATTR_UNDER] = 1'b1;
            SGR_REVERSE:     style_in[ATTR_REV]   = 1'b1;
            SGR_NORMAL: begin
               style_in[ATTR_BOLD] = 1'b0;
               style_in[ATTR_DIM]  = 1'b0;
            end
            SGR_UNDER_OFF:   style_in[ATTR_UNDER] = 1'b0;
            SGR_REVERSE_OFF: style_in[ATTR_REV]   = 1'b0;
            SGR_FG_DEFAULT:  fore_in = FORE_DEFAULT;
            SGR_BG_DEFAULT:  back_in = BACK_DEFAULT;
            [SGR_FG_LO:SGR_FG_HI]: fore_in = 4'(param_ff - SGR_FG_LO);
            [SGR_BG_LO:SGR_BG_HI]: back_in = 4'(param_ff - SGR_BG_LO);
            [SGR_FG_BRIGHT_LO:SGR_FG_BRIGHT_HI]:
               fore_in = 4'(param_ff - SGR_FG_BRIGHT_LO) | 4'h8;
            [SGR_BG_BRIGHT_LO:SGR_BG_BRIGHT_HI]:
               back_in = 4'(param_ff - SGR_BG_BRIGHT_LO) | 4'h8;
            default: ;
         endcase
      end
   end

   // effective colors: bold brightens, dim halves, reverse swaps
   always_comb begin
      fg_lookup = fore_in;
      if (style_in[ATTR_BOLD] && !fore_in[3]) begin
         fg_lookup = {1'b1, fore_in[2:0]};
      end
      fg_rgb = PALETTE[fg_lookup];
      bg_rgb = PALETTE[back_in];
      if (style_in[ATTR_DIM]) begin
         fg_rgb = (fg_rgb >> 1) & HALF_MASK;
      end
      fg_eff = style_in[ATTR_REV] ? bg_rgb : fg_rgb;
      bg_eff = style_in[ATTR_REV] ? fg_rgb : bg_rgb;
      rsp_data_in = {3'b000, style_in, back_in, fore_in, style_in[ATTR_UNDER],
                     bg_eff, fg_eff};
   end

   // style state
   always_ff @(posedge clock) begin
      if (reset) begin
         fore_ff  <= FORE_DEFAULT;
         back_ff  <= BACK_DEFAULT;
         style_ff <= STYLE_DEFAULT;
      end else if (step) begin
         fore_ff  <= fore_in;
         back_ff  <= back_in;
         style_ff <= style_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // assertions
   `SGR_ASSERT(a_bold_dim_exclusive, !(style_ff[ATTR_BOLD] && style_ff[ATTR_DIM]),
      "bold and dim both set")
   `SGR_ASSERT_ALWAYS(a_reset_style, reset |=> (fore_ff == FORE_DEFAULT &&
      back_ff == BACK_DEFAULT && style_ff == STYLE_DEFAULT && !rsp_valid_ff),
      "style not at defaults after reset")
   `SGR_ASSERT(a_state_hold, !step |=> ($stable(fore_ff) && $stable(back_ff) &&
      $stable(style_ff)), "style changed without a transaction")
   `SGR_ASSERT(a_rsp_matches_state, rsp_valid_ff |-> (rsp_data_ff[52:49] == fore_ff &&
      rsp_data_ff[56:53] == back_ff && rsp_data_ff[60:57] == style_ff),
      "pending result disagrees with stored style")

endmodule
`default_nettype wire
